@@ src/nau_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the neuron activation unit.
// No dependencies; every other file refers to this package by scoped names.
package nau_pkg;

	localparam logic [2:0] ACT_SIGMOID = 3'd0;
	localparam logic [2:0] ACT_TANH    = 3'd1;
	localparam logic [2:0] ACT_RELU    = 3'd2;
	localparam logic [2:0] ACT_LEAKY   = 3'd3;
	localparam logic [2:0] ACT_ADAPT   = 3'd4;

	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
	localparam logic signed [16:0] TEN_Q8  = 17'sd2560;

	// tanh quotient bits and divider operand widths
	localparam int QB    = 16;
	localparam int NUM_W = 54;
	localparam int DEN_W = 38;

	typedef struct packed {
		logic [2:0]         act;
		logic signed [15:0] x;
		logic signed [15:0] thr;
		logic signed [15:0] step;
		logic signed [15:0] rest;
	} in_t;

	// per-word data that rides alongside the tanh datapath
	typedef struct packed {
		logic               is_tanh;
		logic               neg;
		logic               sat;
		logic signed [15:0] y_other;
		logic signed [15:0] nthr;
	} side_t;

endpackage

@@ src/nau_misc.sv @@
`timescale 1ns / 1ps
// Two-stage path for sigmoid, relu, leaky relu, passthrough and threshold update.
// Depends on nau_pkg.
module nau_misc (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_in,
	input  nau_pkg::in_t     d_in,
	output logic             v_out,
	output nau_pkg::side_t   side_out,
	output logic [10:0]      a_out
);

	logic               neg;
	logic [15:0]        mag;
	logic [15:0]        smag;
	logic signed [15:0] pass_v;
	logic [15:0]        sig_y;
	logic signed [15:0] sig_v;
	logic [21:0]        lv;
	logic [16:0]        tv;

	logic               v_s1;
	logic [2:0]         act_s1;
	logic               neg_s1;
	logic               xpos_s1;
	logic [15:0]        mag_s1;
	logic signed [15:0] pass_s1;
	logic signed [15:0] sig_s1;
	logic [44:0]        lprod_s1;
	logic [32:0]        tprod_s1;
	logic               sneg_s1;
	logic signed [15:0] x_s1;
	logic signed [15:0] thr_s1;
	logic signed [15:0] step_s1;
	logic signed [15:0] rest_s1;

	logic [15:0]        lf;
	logic signed [16:0] leaky17;
	logic signed [15:0] leaky_v;
	logic signed [15:0] relu_v;
	logic signed [15:0] y_other;
	logic [11:0]        tenth;
	logic signed [16:0] tenth17;
	logic signed [16:0] thr17;
	logic signed [16:0] sum17;
	logic signed [16:0] cand17;
	logic signed [16:0] flo17;
	logic signed [16:0] pick17;
	logic signed [15:0] nthr;

	logic               v_s2;
	nau_pkg::side_t     side_s2;
	logic [10:0]        a_s2;

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		if (v > 17'sd32767)
			return 16'sd32767;
		else if (v < -17'sd32768)
			return -16'sd32768;
		else
			return v[15:0];
	endfunction

	// stage 1: magnitudes, piecewise-linear sigmoid, reciprocal products
	always_comb begin
		neg  = d_in.x[15];
		mag  = neg ? (~d_in.x + 16'd1) : d_in.x;
		smag = d_in.step[15] ? (~d_in.step + 16'd1) : d_in.step;
		if (d_in.x >= 16'sd256)
			pass_v = nau_pkg::ONE_Q14;
		else if (d_in.x <= -16'sd256)
			pass_v = -nau_pkg::ONE_Q14;
		else
			pass_v = d_in.x <<< 6;
		if (mag < 16'd256)
			sig_y = (mag << 4) + 16'd8192;
		else if (mag < 16'd608)
			sig_y = (mag << 3) + 16'd10240;
		else if (mag < 16'd1280)
			sig_y = (mag << 1) + 16'd13824;
		else
			sig_y = 16'd16384;
		sig_v = neg ? $signed(16'd16384 - sig_y) : $signed(sig_y);
		// x*64/100 and step/10 via reciprocal multiply, exact over these ranges
		lv = {mag, 6'b0} + 22'd50;
		tv = {1'b0, smag} + 17'd5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= v_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1   <= d_in.act;
			neg_s1   <= neg;
			xpos_s1  <= !neg && (d_in.x != 16'sd0);
			mag_s1   <= mag;
			pass_s1  <= pass_v;
			sig_s1   <= sig_v;
			lprod_s1 <= 45'(lv) * 45'd5368710;
			tprod_s1 <= 33'(tv) * 33'd52429;
			sneg_s1  <= d_in.step[15];
			x_s1     <= d_in.x;
			thr_s1   <= d_in.thr;
			step_s1  <= d_in.step;
			rest_s1  <= d_in.rest;
		end
	end

	// stage 2: selection and threshold update
	always_comb begin
		lf      = lprod_s1[44:29];
		leaky17 = (lf > 16'd16384) ? -17'sd16384 : -$signed({1'b0, lf});
		leaky_v = xpos_s1 ? pass_s1 : leaky17[15:0];
		relu_v  = xpos_s1 ? pass_s1 : 16'sd0;
		unique case (act_s1)
			nau_pkg::ACT_SIGMOID: y_other = sig_s1;
			nau_pkg::ACT_RELU:    y_other = relu_v;
			nau_pkg::ACT_LEAKY:   y_other = leaky_v;
			default:              y_other = pass_s1;
		endcase
		tenth   = tprod_s1[30:19];
		tenth17 = sneg_s1 ? -$signed({5'b0, tenth}) : $signed({5'b0, tenth});
		thr17   = 17'(thr_s1);
		sum17   = thr17 + 17'(step_s1);
		cand17  = thr17 - tenth17;
		flo17   = 17'(rest_s1) + nau_pkg::TEN_Q8;
		pick17  = (cand17 > flo17) ? cand17 : flo17;
		if (act_s1 != nau_pkg::ACT_ADAPT)
			nthr = thr_s1;
		else if (x_s1 > thr_s1)
			nthr = sat16(sum17);
		else
			nthr = sat16(pick17);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.is_tanh <= (act_s1 == nau_pkg::ACT_TANH);
			side_s2.neg     <= neg_s1;
			side_s2.sat     <= (mag_s1 > 16'd1024);
			side_s2.y_other <= y_other;
			side_s2.nthr    <= nthr;
			a_s2            <= mag_s1[10:0];
		end
	end

	assign v_out    = v_s2;
	assign side_out = side_s2;
	assign a_out    = a_s2;

endmodule

@@ src/nau_tanh.sv @@
`timescale 1ns / 1ps
// Pade numerator and denominator for tanh, Horner form, pipelined.
// Depends on nau_pkg.
module nau_tanh (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_in,
	input  nau_pkg::side_t              side_in,
	input  logic [10:0]                 a_in,
	output logic                        v_out,
	output nau_pkg::side_t              side_out,
	output logic [nau_pkg::NUM_W-1:0]   num_out,
	output logic [nau_pkg::DEN_W-1:0]   den_out
);

	localparam int NW = nau_pkg::NUM_W;

	logic [5:0]  v_s;
	nau_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;

	logic [10:0] a_s1, a_s2, a_s3, a_s4;
	logic [20:0] t2_s1, t2_s2, t2_s3;
	logic [24:0] p1_s2;
	logic [27:0] q1_s2;
	logic [30:0] p2_s3;
	logic [32:0] q2_s3;
	logic [35:0] p3_s4;
	logic [37:0] q3_s4, q3_s5;
	logic [46:0] mp_s5;
	logic [nau_pkg::NUM_W-1:0] num_s6;
	logic [nau_pkg::DEN_W-1:0] den_s6;

	logic [45:0] pp2;
	logic [48:0] qp2;
	logic [51:0] pp3;
	logic [53:0] qp3;

	always_comb begin
		pp2 = 46'(t2_s2) * 46'(p1_s2);
		qp2 = 49'(t2_s2) * 49'(q1_s2);
		pp3 = 52'(t2_s3) * 52'(p2_s3);
		qp3 = 54'(t2_s3) * 54'(q2_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[4:0], v_in};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= a_in;
			t2_s1   <= 21'(a_in) * 21'(a_in);
			side_s1 <= side_in;

			a_s2    <= a_s1;
			t2_s2   <= t2_s1;
			p1_s2   <= 25'd24772608 + 25'(t2_s1);
			q1_s2   <= 28'd206438400 + 28'(t2_s1) * 28'd28;
			side_s2 <= side_s1;

			a_s3    <= a_s2;
			t2_s3   <= t2_s2;
			p2_s3   <= 31'd1135411200 + 31'(pp2 >> 16);
			q2_s3   <= 33'd4087480320 + 33'(qp2 >> 16);
			side_s3 <= side_s2;

			a_s4    <= a_s3;
			p3_s4   <= 36'd8856207360 + 36'(pp3 >> 16);
			q3_s4   <= 38'd8856207360 + 38'(qp3 >> 16);
			side_s4 <= side_s3;

			mp_s5   <= 47'(a_s4) * 47'(p3_s4);
			q3_s5   <= q3_s4;
			side_s5 <= side_s4;

			// numerator in Q14 scale plus half the divisor for rounding
			num_s6  <= {1'b0, mp_s5, 6'b0} + NW'(q3_s5 >> 1);
			den_s6  <= q3_s5;
			side_s6 <= side_s5;
		end
	end

	assign v_out    = v_s[5];
	assign side_out = side_s6;
	assign num_out  = num_s6;
	assign den_out  = den_s6;

endmodule

@@ src/nau_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per pipeline stage.
// Depends on nau_pkg.
module nau_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_in,
	input  nau_pkg::side_t              side_in,
	input  logic [nau_pkg::NUM_W-1:0]   num_in,
	input  logic [nau_pkg::DEN_W-1:0]   den_in,
	output logic                        v_out,
	output nau_pkg::side_t              side_out,
	output logic [nau_pkg::QB-1:0]      quo_out
);

	localparam int NW = nau_pkg::NUM_W;
	localparam int DW = nau_pkg::DEN_W;
	localparam int QB = nau_pkg::QB;

	logic [NW-1:0]   rem_s  [1:QB-1];
	logic [DW-1:0]   den_s  [1:QB-1];
	logic [QB-1:0]   quo_s  [1:QB];
	nau_pkg::side_t  side_s [1:QB];
	logic [QB:1]     v_s;

	logic [NW-1:0]   cur_rem  [0:QB-1];
	logic [DW-1:0]   cur_den  [0:QB-1];
	logic [QB-1:0]   cur_quo  [0:QB-1];
	nau_pkg::side_t  cur_side [0:QB-1];
	logic [NW-1:0]   nxt_rem  [0:QB-1];
	logic [QB-1:0]   nxt_quo  [0:QB-1];
	logic [NW:0]     trial    [0:QB-1];

	always_comb begin
		cur_rem[0]  = num_in;
		cur_den[0]  = den_in;
		cur_quo[0]  = '0;
		cur_side[0] = side_in;
		for (int i = 1; i < QB; i++) begin
			cur_rem[i]  = rem_s[i];
			cur_den[i]  = den_s[i];
			cur_quo[i]  = quo_s[i];
			cur_side[i] = side_s[i];
		end
		for (int i = 0; i < QB; i++) begin
			trial[i] = {1'b0, cur_rem[i]} - ((NW + 1)'(cur_den[i]) << (QB - 1 - i));
			if (!trial[i][NW]) begin
				nxt_rem[i] = trial[i][NW-1:0];
				nxt_quo[i] = cur_quo[i] | (QB'(1) << (QB - 1 - i));
			end else begin
				nxt_rem[i] = cur_rem[i];
				nxt_quo[i] = cur_quo[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[QB-1:1], v_in};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < QB; i++) begin
				quo_s[i+1]  <= nxt_quo[i];
				side_s[i+1] <= cur_side[i];
			end
			// the last stage keeps only the quotient and the side data
			for (int i = 0; i < QB - 1; i++) begin
				rem_s[i+1] <= nxt_rem[i];
				den_s[i+1] <= cur_den[i];
			end
		end
	end

	assign v_out    = v_s[QB];
	assign side_out = side_s[QB];
	assign quo_out  = quo_s[QB];

endmodule

@@ src/neuron_activation_unit_core.sv @@
`timescale 1ns / 1ps
// Top level of the neuron activation unit: input register, datapath, output skid.
// Depends on nau_pkg, nau_misc, nau_tanh, nau_div.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------------
//  item     | item_valid / item_stall     | action, input_value, threshold_in,
//           |                             | adapt_step, rest_level
//  result   | result_valid / result_stall | activation, threshold_out
//
// One word accepted per cycle while item_stall is low; every word takes the tanh path
// (six Horner/product stages and a 16-stage one-bit-per-stage divider).
// Reset clears all valid bits; payload registers are not reset.
// A skid register behind the output register absorbs the word in flight when
// result_stall rises; item_stall is the registered skid-full flag.
module neuron_activation_unit_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [2:0]         action,
	input  logic signed [15:0] input_value,
	input  logic signed [15:0] threshold_in,
	input  logic signed [15:0] adapt_step,
	input  logic signed [15:0] rest_level,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [15:0] activation,
	output logic signed [15:0] threshold_out
);

	logic               en;
	logic               v_s1;
	nau_pkg::in_t       in_s1;

	logic               misc_v;
	nau_pkg::side_t     misc_side;
	logic [10:0]        misc_a;

	logic               tanh_v;
	nau_pkg::side_t     tanh_side;
	logic [nau_pkg::NUM_W-1:0] tanh_num;
	logic [nau_pkg::DEN_W-1:0] tanh_den;

	logic               div_v;
	nau_pkg::side_t     div_side;
	logic [nau_pkg::QB-1:0] div_quo;

	logic [15:0]        r_clip;
	logic [15:0]        tanh_mag;
	logic signed [15:0] fin_act;

	logic               out_v_q;
	logic signed [15:0] out_act_q;
	logic signed [15:0] out_thr_q;
	logic               skid_v_q;
	logic signed [15:0] skid_act_q;
	logic signed [15:0] skid_thr_q;
	logic               out_free;

	assign en         = !skid_v_q;
	assign item_stall = skid_v_q;
	assign out_free   = !out_v_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1.act  <= action;
			in_s1.x    <= input_value;
			in_s1.thr  <= threshold_in;
			in_s1.step <= adapt_step;
			in_s1.rest <= rest_level;
		end
	end

	nau_misc u_misc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s1),
		.d_in     (in_s1),
		.v_out    (misc_v),
		.side_out (misc_side),
		.a_out    (misc_a)
	);

	nau_tanh u_tanh (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (misc_v),
		.side_in  (misc_side),
		.a_in     (misc_a),
		.v_out    (tanh_v),
		.side_out (tanh_side),
		.num_out  (tanh_num),
		.den_out  (tanh_den)
	);

	nau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (tanh_v),
		.side_in  (tanh_side),
		.num_in   (tanh_num),
		.den_in   (tanh_den),
		.v_out    (div_v),
		.side_out (div_side),
		.quo_out  (div_quo)
	);

	always_comb begin
		r_clip   = (div_quo > 16'd16384) ? 16'd16384 : div_quo;
		tanh_mag = div_side.sat ? 16'd16384 : r_clip;
		if (!div_side.is_tanh)
			fin_act = div_side.y_other;
		else if (div_side.neg)
			fin_act = -$signed(tanh_mag);
		else
			fin_act = $signed(tanh_mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= div_v;
			end
		end else if (div_v && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_act_q <= skid_act_q;
				out_thr_q <= skid_thr_q;
			end else begin
				out_act_q <= fin_act;
				out_thr_q <= div_side.nthr;
			end
		end else if (div_v && en) begin
			skid_act_q <= fin_act;
			skid_thr_q <= div_side.nthr;
		end
	end

	assign result_valid  = out_v_q;
	assign activation    = out_act_q;
	assign threshold_out = out_thr_q;

endmodule
